[rtl/cps_pkg.sv]
// Shared types for the channel packet statistics table.
// Holds the request opcode, the record layout, the result layout and the
// control bundle that the top level hands to the update unit. No dependencies.
package cps_pkg;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_RX     = 2'd0,
    OP_TX     = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // One per-channel record as it travels along the row of cells.
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] rx_packets;
    logic [31:0] rx_tx_sum;
    logic [31:0] rx_listen_sum;
    logic [31:0] tx_packets;
    logic [31:0] tx_tx_sum;
    logic [31:0] tx_listen_sum;
    logic [31:0] snap_rx_tx;
    logic [31:0] snap_rx_listen;
    logic [31:0] snap_tx_tx;
    logic [31:0] snap_tx_listen;
  } rec_t;

  // One reported record.
  typedef struct packed {
    logic [15:0] rec_channel;
    logic [31:0] in_count;
    logic [31:0] in_tx_total;
    logic [31:0] in_listen_total;
    logic [31:0] in_tx_delta;
    logic [31:0] in_listen_delta;
    logic [31:0] out_count;
    logic [31:0] out_tx_total;
    logic [31:0] out_listen_total;
    logic [31:0] out_tx_delta;
    logic [31:0] out_listen_delta;
    logic        last;
  } res_t;

  // Control from the sequencer to the update unit for the record at the tap.
  typedef struct packed {
    op_t         op;
    logic [15:0] channel;
    logic [15:0] tx_time;
    logic [15:0] listen_time;
    logic        searching;  // no record has matched this request yet
    logic        in_use;     // the tap record is one of the live records
    logic        at_end;     // the tap is at the first free slot
    logic        room;       // the table still has a free slot
    logic        is_last;    // the tap record is the final live record
  } ctl_t;

  // Status back from the update unit.
  typedef struct packed {
    logic hit;    // existing record matched and updated
    logic alloc;  // new record created at the tap
    logic emit;   // tap record is reported this step
  } sts_t;

endpackage

[rtl/cps_ifs.sv]
// Handshake channels of the channel packet statistics table.
// cps_req_if carries packet events and report requests, cps_res_if the
// reported records. Depends on nothing.
interface cps_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] channel;
  logic [15:0] tx_time;
  logic [15:0] listen_time;

  modport source (output valid, output op, output channel, output tx_time,
                  output listen_time, input ready);
  modport sink (input valid, input op, input channel, input tx_time,
                input listen_time, output ready);
endinterface

interface cps_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] rec_channel;
  logic [31:0] in_count;
  logic [31:0] in_tx_total;
  logic [31:0] in_listen_total;
  logic [31:0] in_tx_delta;
  logic [31:0] in_listen_delta;
  logic [31:0] out_count;
  logic [31:0] out_tx_total;
  logic [31:0] out_listen_total;
  logic [31:0] out_tx_delta;
  logic [31:0] out_listen_delta;
  logic        last;

  modport source (output valid, output rec_channel, output in_count,
                  output in_tx_total, output in_listen_total, output in_tx_delta,
                  output in_listen_delta, output out_count, output out_tx_total,
                  output out_listen_total, output out_tx_delta,
                  output out_listen_delta, output last, input ready);
  modport sink (input valid, input rec_channel, input in_count,
                input in_tx_total, input in_listen_total, input in_tx_delta,
                input in_listen_delta, input out_count, input out_tx_total,
                input out_listen_total, input out_tx_delta,
                input out_listen_delta, input last, output ready);
endinterface

[rtl/cps_cell.sv]
// One storage cell of the record ring: holds a record and takes its
// neighbor's record on every shift. Depends on cps_pkg.
module cps_cell (
  input  logic          clk,
  input  logic          shift,
  input  cps_pkg::rec_t rec_in,
  output cps_pkg::rec_t rec_out
);

  cps_pkg::rec_t rec;

  // Payload register, no reset: a slot is zeroed when it is allocated.
  always_ff @(posedge clk) begin
    if (shift) begin
      rec <= rec_in;
    end
  end

  assign rec_out = rec;

endmodule

[rtl/cps_tap.sv]
// Update unit at the wrap point of the record ring: matches, allocates,
// accumulates and reports the record passing by. Depends on cps_pkg.
module cps_tap (
  input  cps_pkg::ctl_t rec_ctl,
  input  cps_pkg::rec_t rec_in,
  output cps_pkg::rec_t rec_out,
  output cps_pkg::res_t res,
  output cps_pkg::sts_t sts
);

  logic          is_pkt;
  logic          match;
  logic          alloc;
  cps_pkg::rec_t base;
  logic [31:0]   tx_ext;
  logic [31:0]   ls_ext;

  assign is_pkt = (rec_ctl.op == cps_pkg::OP_RX) || (rec_ctl.op == cps_pkg::OP_TX);
  assign match  = is_pkt && rec_ctl.searching && rec_ctl.in_use &&
                  (rec_in.key == rec_ctl.channel);
  assign alloc  = is_pkt && rec_ctl.searching && rec_ctl.at_end && rec_ctl.room;
  assign tx_ext = {16'd0, rec_ctl.tx_time};
  assign ls_ext = {16'd0, rec_ctl.listen_time};

  // Record after this step: fresh zeroed record on allocation, sums on a hit or an allocation, snapshots on a report.
  always_comb begin
    base = rec_in;
    if (alloc) begin
      base     = '0;
      base.key = rec_ctl.channel;
    end
    rec_out = base;
    if (match || alloc) begin
      if (rec_ctl.op == cps_pkg::OP_TX) begin
        rec_out.tx_packets    = base.tx_packets + 32'd1;
        rec_out.tx_tx_sum     = base.tx_tx_sum + tx_ext;
        rec_out.tx_listen_sum = base.tx_listen_sum + ls_ext;
      end else begin
        rec_out.rx_packets    = base.rx_packets + 32'd1;
        rec_out.rx_tx_sum     = base.rx_tx_sum + tx_ext;
        rec_out.rx_listen_sum = base.rx_listen_sum + ls_ext;
      end
    end
    if (sts.emit) begin
      rec_out.snap_rx_tx     = rec_in.rx_tx_sum;
      rec_out.snap_rx_listen = rec_in.rx_listen_sum;
      rec_out.snap_tx_tx     = rec_in.tx_tx_sum;
      rec_out.snap_tx_listen = rec_in.tx_listen_sum;
    end
  end

  // Report fields of the record passing by.
  always_comb begin
    res.rec_channel      = rec_in.key;
    res.in_count         = rec_in.rx_packets;
    res.in_tx_total      = rec_in.rx_tx_sum;
    res.in_listen_total  = rec_in.rx_listen_sum;
    res.in_tx_delta      = rec_in.rx_tx_sum - rec_in.snap_rx_tx;
    res.in_listen_delta  = rec_in.rx_listen_sum - rec_in.snap_rx_listen;
    res.out_count        = rec_in.tx_packets;
    res.out_tx_total     = rec_in.tx_tx_sum;
    res.out_listen_total = rec_in.tx_listen_sum;
    res.out_tx_delta     = rec_in.tx_tx_sum - rec_in.snap_tx_tx;
    res.out_listen_delta = rec_in.tx_listen_sum - rec_in.snap_tx_listen;
    res.last             = rec_ctl.is_last;
  end

  assign sts.hit   = match;
  assign sts.alloc = alloc;
  assign sts.emit  = (rec_ctl.op == cps_pkg::OP_REPORT) && rec_ctl.in_use;

endmodule

[rtl/channel_packet_stats_table.sv]
// Top level of the channel packet statistics table: a ring of record cells,
// the update unit at its wrap point, the sequencer and the result register.
// Depends on cps_pkg, cps_ifs, cps_cell and cps_tap.
//
//   port   direction  content
//   req    in         op, channel, tx_time, listen_time
//   res    out        one reported record with totals, deltas and last
//
// Every request rotates the ring once: MAX_ENTRIES shift steps after the accept.
// A report step stalls while the result register holds a record not taken.
// Records leave the ring in insertion order; a new request is taken only
// after the rotation ends. Reset clears the record count and the sequencer.
module channel_packet_stats_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  cps_req_if.sink   req,
  cps_res_if.source res
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cps_pkg::state_t state, state_next;
  logic [CW-1:0]   entry_count;
  logic [SW-1:0]   step;
  logic            matched;
  cps_pkg::ctl_t   cmd;
  cps_pkg::ctl_t   rec_ctl;
  cps_pkg::rec_t   ring [MAX_ENTRIES];
  cps_pkg::rec_t   tap_out;
  cps_pkg::res_t   tap_res;
  cps_pkg::sts_t   tap_sts;
  cps_pkg::res_t   res_data;
  logic            res_valid;
  logic            accept;
  logic            advance;
  logic            last_step;
  logic [CW-1:0]   step_ext;

  assign accept    = req.valid && req.ready;
  assign step_ext  = CW'(step);
  assign last_step = (step == SW'(MAX_ENTRIES - 1));
  // A step moves the ring unless it must report into a full result register.
  assign advance   = (state == cps_pkg::ST_RUN) &&
                     (!tap_sts.emit || !res_valid || res.ready);

  // Control for the record now at the tap.
  always_comb begin
    rec_ctl           = cmd;
    rec_ctl.searching = !matched;
    rec_ctl.in_use    = step_ext < entry_count;
    rec_ctl.at_end    = step_ext == entry_count;
    rec_ctl.room      = entry_count < CW'(MAX_ENTRIES);
    rec_ctl.is_last   = step_ext == (entry_count - 1'b1);
  end

  // Row of cells; cell 0 is the tap and wraps to the far end.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cps_pkg::rec_t nbr;
    if (i == MAX_ENTRIES - 1) begin : g_wrap
      assign nbr = tap_out;
    end else begin : g_link
      assign nbr = ring[i+1];
    end
    cps_cell u_cell (
      .clk     (clk),
      .shift   (advance),
      .rec_in  (nbr),
      .rec_out (ring[i])
    );
  end

  cps_tap u_tap (
    .rec_ctl (rec_ctl),
    .rec_in  (ring[0]),
    .rec_out (tap_out),
    .res     (tap_res),
    .sts     (tap_sts)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cps_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = cps_pkg::ST_RUN;
        end
      end
      cps_pkg::ST_RUN: begin
        if (advance && last_step) begin
          state_next = cps_pkg::ST_IDLE;
        end
      end
      default: state_next = cps_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    unique case (state)
      cps_pkg::ST_IDLE: req.ready = 1'b1;
      cps_pkg::ST_RUN:  req.ready = 1'b0;
      default:          req.ready = 1'b0;
    endcase
  end

  // Sequencer, step counter, match flag and record count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cps_pkg::ST_IDLE;
      step        <= '0;
      matched     <= 1'b0;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step    <= '0;
        matched <= 1'b0;
      end else if (advance) begin
        step <= last_step ? '0 : step + 1'b1;
        if (tap_sts.hit || tap_sts.alloc) begin
          matched <= 1'b1;
        end
        if (tap_sts.alloc) begin
          entry_count <= entry_count + 1'b1;
        end
      end
    end
  end

  // Request fields held for the whole rotation.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= '{op: cps_pkg::op_t'(req.op), channel: req.channel,
               tx_time: req.tx_time, listen_time: req.listen_time, default: 1'b0};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && tap_sts.emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tap_sts.emit) begin
      res_data <= tap_res;
    end
  end

  assign res.valid            = res_valid;
  assign res.rec_channel      = res_data.rec_channel;
  assign res.in_count         = res_data.in_count;
  assign res.in_tx_total      = res_data.in_tx_total;
  assign res.in_listen_total  = res_data.in_listen_total;
  assign res.in_tx_delta      = res_data.in_tx_delta;
  assign res.in_listen_delta  = res_data.in_listen_delta;
  assign res.out_count        = res_data.out_count;
  assign res.out_tx_total     = res_data.out_tx_total;
  assign res.out_listen_total = res_data.out_listen_total;
  assign res.out_tx_delta     = res_data.out_tx_delta;
  assign res.out_listen_delta = res_data.out_listen_delta;
  assign res.last             = res_data.last;

  // The record count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES))
    else $error("record count beyond table size");

  // An allocation grows the table by exactly one record.
  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    advance && tap_sts.alloc |=> entry_count == $past(entry_count) + 1'b1)
    else $error("allocation did not grow the table");

  // A request never both matches and allocates.
  a_hit_alloc: assert property (@(posedge clk) disable iff (rst)
    !(tap_sts.hit && tap_sts.alloc))
    else $error("match and allocation at once");

  // One rotation finishes back in idle with the step counter rewound.
  a_rotation_end: assert property (@(posedge clk) disable iff (rst)
    advance && last_step |=> state == cps_pkg::ST_IDLE && step == '0)
    else $error("rotation did not end cleanly");

  // A pending result is never overwritten by the next report step.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |-> !(advance && tap_sts.emit))
    else $error("result overwritten before it was taken");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench for channel_packet_stats_table: drives packet events and report requests,
// predicts every reported record and checks each one as it leaves the block.
// Depends on cps_pkg, cps_ifs and the RTL of the table.
module tb;

  localparam int MAX_ENTRIES = 16;
  localparam int HOLD_AT = 160;
  localparam int HOLD_CYCLES = 500;

  // One request as the driver sends it.
  typedef struct {
    cps_pkg::op_t op;
    logic [15:0]  channel;
    logic [15:0]  tx_time;
    logic [15:0]  listen_time;
  } pkt_req_t;

  logic clk = 1'b0;
  logic rst;

  cps_req_if req_ch();
  cps_res_if res_ch();

  channel_packet_stats_table #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Stimulus and bookkeeping.
  pkt_req_t      events_to_send[$];
  cps_pkg::res_t due_records[$];
  logic [15:0]   known_ch[MAX_ENTRIES];
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_results = 0;
  int            mismatches = 0;
  int            send_gap = 0;
  int            recv_gap = 0;
  bit            req_taken = 1'b0;
  bit            calm = 1'b0;
  bit            hold_res = 1'b0;

  // Predicted contents of the table.
  cps_pkg::rec_t stats_tab[MAX_ENTRIES];
  int            live_recs = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Update the predicted table for one accepted request and queue the records it reports.
  function automatic void account_request(pkt_req_t ev);
    int            slot;
    cps_pkg::res_t r;
    slot = -1;
    case (ev.op)
      cps_pkg::OP_RX, cps_pkg::OP_TX: begin
        for (int i = 0; i < live_recs; i++)
          if (stats_tab[i].key == ev.channel) slot = i;
        if (slot < 0) begin
          // Unknown channel on a full table: the event is dropped.
          if (live_recs == MAX_ENTRIES) return;
          slot = live_recs;
          stats_tab[slot] = '0;
          stats_tab[slot].key = ev.channel;
          live_recs++;
        end
        if (ev.op == cps_pkg::OP_TX) begin
          stats_tab[slot].tx_packets    = stats_tab[slot].tx_packets + 32'd1;
          stats_tab[slot].tx_tx_sum     = stats_tab[slot].tx_tx_sum + 32'(ev.tx_time);
          stats_tab[slot].tx_listen_sum = stats_tab[slot].tx_listen_sum + 32'(ev.listen_time);
        end else begin
          stats_tab[slot].rx_packets    = stats_tab[slot].rx_packets + 32'd1;
          stats_tab[slot].rx_tx_sum     = stats_tab[slot].rx_tx_sum + 32'(ev.tx_time);
          stats_tab[slot].rx_listen_sum = stats_tab[slot].rx_listen_sum + 32'(ev.listen_time);
        end
      end
      cps_pkg::OP_REPORT: begin
        for (int i = 0; i < live_recs; i++) begin
          r.rec_channel      = stats_tab[i].key;
          r.in_count         = stats_tab[i].rx_packets;
          r.in_tx_total      = stats_tab[i].rx_tx_sum;
          r.in_listen_total  = stats_tab[i].rx_listen_sum;
          r.in_tx_delta      = stats_tab[i].rx_tx_sum - stats_tab[i].snap_rx_tx;
          r.in_listen_delta  = stats_tab[i].rx_listen_sum - stats_tab[i].snap_rx_listen;
          r.out_count        = stats_tab[i].tx_packets;
          r.out_tx_total     = stats_tab[i].tx_tx_sum;
          r.out_listen_total = stats_tab[i].tx_listen_sum;
          r.out_tx_delta     = stats_tab[i].tx_tx_sum - stats_tab[i].snap_tx_tx;
          r.out_listen_delta = stats_tab[i].tx_listen_sum - stats_tab[i].snap_tx_listen;
          r.last             = (i == live_recs - 1);
          due_records.push_back(r);
          stats_tab[i].snap_rx_tx     = stats_tab[i].rx_tx_sum;
          stats_tab[i].snap_rx_listen = stats_tab[i].rx_listen_sum;
          stats_tab[i].snap_tx_tx     = stats_tab[i].tx_tx_sum;
          stats_tab[i].snap_tx_listen = stats_tab[i].tx_listen_sum;
        end
      end
      default: ;
    endcase
  endfunction

  // Compare one field of a reported record.
  task automatic note_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on %s of record %0d: expected %h, got %h",
                 name, n_results, want, got);
      mismatches++;
    end
  endtask

  task automatic push_req(cps_pkg::op_t op, logic [15:0] ch, logic [15:0] tx,
                          logic [15:0] ls);
    pkt_req_t ev;
    ev.op = op;
    ev.channel = ch;
    ev.tx_time = tx;
    ev.listen_time = ls;
    events_to_send.push_back(ev);
    n_queued++;
  endtask

  // Times lean toward both extremes.
  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly known channels, which hit live records; the rest are noise that gets dropped.
  task automatic queue_random(int count);
    int           pick;
    cps_pkg::op_t op;
    logic [15:0]  ch;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = cps_pkg::OP_RX;
      else if (pick < 75) op = cps_pkg::OP_TX;
      else if (pick < 95) op = cps_pkg::OP_REPORT;
      else op = cps_pkg::OP_NONE;
      if ($urandom_range(0, 4) != 0) ch = known_ch[$urandom_range(0, MAX_ENTRIES - 1)];
      else ch = 16'($urandom);
      push_req(op, ch, pick_time(), pick_time());
    end
  endtask

  task automatic wait_all_done();
    while (n_accepted != n_queued || due_records.size() != 0) @(posedge clk);
  endtask

  // Request driver: changes on the falling edge.
  always @(negedge clk) begin
    pkt_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (events_to_send.size() != 0) begin
        nxt = events_to_send.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.op <= nxt.op;
        req_ch.channel <= nxt.channel;
        req_ch.tx_time <= nxt.tx_time;
        req_ch.listen_time <= nxt.listen_time;
        if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 19);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side ready: random stall bursts, plus the long hold-off.
  always @(negedge clk) begin
    if (rst || hold_res) begin
      res_ch.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 11) == 0) recv_gap <= $urandom_range(1, 19);
    end
  end

  // Monitor: records accepted requests and checks reported records on the rising edge.
  always @(posedge clk) begin
    pkt_req_t      seen;
    cps_pkg::res_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (due_records.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected record for channel %h", res_ch.rec_channel);
          mismatches++;
        end else begin
          want = due_records.pop_front();
          note_field("rec_channel", res_ch.rec_channel, want.rec_channel);
          note_field("in_count", res_ch.in_count, want.in_count);
          note_field("in_tx_total", res_ch.in_tx_total, want.in_tx_total);
          note_field("in_listen_total", res_ch.in_listen_total, want.in_listen_total);
          note_field("in_tx_delta", res_ch.in_tx_delta, want.in_tx_delta);
          note_field("in_listen_delta", res_ch.in_listen_delta, want.in_listen_delta);
          note_field("out_count", res_ch.out_count, want.out_count);
          note_field("out_tx_total", res_ch.out_tx_total, want.out_tx_total);
          note_field("out_listen_total", res_ch.out_listen_total, want.out_listen_total);
          note_field("out_tx_delta", res_ch.out_tx_delta, want.out_tx_delta);
          note_field("out_listen_delta", res_ch.out_listen_delta, want.out_listen_delta);
          note_field("last", res_ch.last, want.last);
        end
        n_results++;
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.op = cps_pkg::op_t'(req_ch.op);
        seen.channel = req_ch.channel;
        seen.tx_time = req_ch.tx_time;
        seen.listen_time = req_ch.listen_time;
        account_request(seen);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // Long receiver hold-off in the middle of the second random batch, so the table backs up.
  initial begin
    while (n_accepted < HOLD_AT) @(posedge clk);
    hold_res = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_res = 1'b0;
  end

  // Overall time limit.
  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, stimulus and end of run.
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = cps_pkg::OP_NONE;
    req_ch.channel = '0;
    req_ch.tx_time = '0;
    req_ch.listen_time = '0;
    res_ch.ready = 1'b0;
    known_ch[0] = 16'h0000;
    known_ch[1] = 16'hFFFF;
    for (int i = 1; i < MAX_ENTRIES - 1; i++) known_ch[i + 1] = 16'(16'h1111 * i);

    // Report on an empty table, then an unused selector that must not allocate.
    push_req(cps_pkg::OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
    push_req(cps_pkg::OP_NONE, 16'h1234, 16'hFFFF, 16'hFFFF);
    // Field extremes on the lowest and highest channel.
    push_req(cps_pkg::OP_RX, 16'h0000, 16'h0000, 16'h0000);
    push_req(cps_pkg::OP_RX, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_req(cps_pkg::OP_TX, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_req(cps_pkg::OP_TX, 16'hFFFF, 16'h0000, 16'hFFFF);
    // Two reports in a row: the second shows zero deltas.
    push_req(cps_pkg::OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
    push_req(cps_pkg::OP_REPORT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_req(cps_pkg::OP_RX, 16'hFFFF, 16'h0001, 16'h0002);
    push_req(cps_pkg::OP_REPORT, 16'h0000, 16'h0000, 16'h0000);
    // Fill the table, then try two channels that no longer fit.
    for (int i = 2; i < MAX_ENTRIES; i++)
      push_req(($urandom_range(0, 1) != 0) ? cps_pkg::OP_TX : cps_pkg::OP_RX, known_ch[i],
               pick_time(), pick_time());
    push_req(cps_pkg::OP_RX, 16'h1234, 16'hFFFF, 16'hFFFF);
    push_req(cps_pkg::OP_TX, 16'h8000, 16'hFFFF, 16'hFFFF);
    push_req(cps_pkg::OP_REPORT, 16'h0000, 16'h0000, 16'h0000);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_random(90);
    // Sender waits here until every expected record has come back.
    wait_all_done();
    queue_random(90);
    wait_all_done();
    // Last stretch without idling on either side.
    calm = 1'b1;
    queue_random(45);
    wait_all_done();
    repeat (4 * MAX_ENTRIES) @(posedge clk);

    if (mismatches == 0 && due_records.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
